@@ hw/rtl/wsp_pkg.sv @@
package wsp_pkg;

    typedef logic signed [31:0] t_q16;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_XFORM = 1'b1;

    localparam logic REG_SCREEN_WIDTH  = 1'b0;
    localparam logic REG_SCREEN_HEIGHT = 1'b1;

    localparam t_q16 Q_ONE     = 32'sd65536;
    localparam t_q16 Q_NEG_ONE = -32'sd65536;
    localparam t_q16 W_MIN     = 32'sd6;

    localparam int DIV_BITS = 32;

    localparam logic [12:0] RESET_WIDTH  = 13'd1920;
    localparam logic [12:0] RESET_HEIGHT = 13'd1080;

    typedef struct packed {
        logic [30:0] rem;
        logic [31:0] dbits;
        logic [31:0] quo;
        logic        neg;
        logic        sat;
    } t_div_lane;

    typedef struct packed {
        logic [30:0] cw;
        logic        reject;
    } t_div_side;

    function automatic t_q16 sat32(input logic signed [49:0] v);
        logic signed [49:0] hi;
        logic signed [49:0] lo;
        hi = 50'sd2147483647;
        lo = -50'sd2147483648;
        if (v > hi) begin
            return 32'sh7fffffff;
        end else if (v < lo) begin
            return 32'sh80000000;
        end
        return t_q16'(v[31:0]);
    endfunction

endpackage

@@ hw/rtl/wsp_vec_mat.sv @@
module wsp_vec_mat (
    input  logic               i_clk,
    input  logic               i_en_mul,
    input  logic               i_en_sum,
    input  wsp_pkg::t_q16      i_vec [4],
    input  wsp_pkg::t_q16      i_mat [16],
    output wsp_pkg::t_q16      o_vec [4]
);

    logic signed [47:0] r_term [16];
    logic signed [47:0] n_term [16];
    wsp_pkg::t_q16      r_sum  [4];
    wsp_pkg::t_q16      n_sum  [4];

    always_comb begin
        logic signed [63:0] p;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                p = i_vec[r] * i_mat[r * 4 + c];
                n_term[r * 4 + c] = $signed(p[63:16]);
            end
        end
    end

    always_comb begin
        logic signed [49:0] acc;
        for (int c = 0; c < 4; c++) begin
            acc = 50'(r_term[c]) + 50'(r_term[4 + c]) + 50'(r_term[8 + c])
                + 50'(r_term[12 + c]);
            n_sum[c] = wsp_pkg::sat32(acc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en_mul) begin
            r_term <= n_term;
        end
        if (i_en_sum) begin
            r_sum <= n_sum;
        end
    end

    assign o_vec = r_sum;

endmodule

@@ hw/rtl/wsp_divider.sv @@
module wsp_divider (
    input  logic                  i_clk,
    input  logic [31:0]           i_en,
    input  wsp_pkg::t_div_lane    i_lane [3],
    input  wsp_pkg::t_div_side    i_side,
    output wsp_pkg::t_div_lane    o_lane [3],
    output wsp_pkg::t_div_side    o_side
);

    wsp_pkg::t_div_lane r_lane [wsp_pkg::DIV_BITS][3];
    wsp_pkg::t_div_side r_side [wsp_pkg::DIV_BITS];

    for (genvar s = 0; s < wsp_pkg::DIV_BITS; s++) begin : g_stage
        wsp_pkg::t_div_lane w_in [3];
        wsp_pkg::t_div_lane n_lane [3];
        wsp_pkg::t_div_side w_side;

        if (s == 0) begin : g_first
            assign w_in   = i_lane;
            assign w_side = i_side;
        end else begin : g_next
            assign w_in   = r_lane[s - 1];
            assign w_side = r_side[s - 1];
        end

        always_comb begin
            logic [31:0] sh;
            logic [31:0] diff;
            logic        ge;
            for (int l = 0; l < 3; l++) begin
                sh   = {w_in[l].rem, w_in[l].dbits[31]};
                ge   = sh >= {1'b0, w_side.cw};
                diff = sh - {1'b0, w_side.cw};
                n_lane[l].rem   = ge ? diff[30:0] : sh[30:0];
                n_lane[l].dbits = {w_in[l].dbits[30:0], 1'b0};
                n_lane[l].quo   = {w_in[l].quo[30:0], ge};
                n_lane[l].neg   = w_in[l].neg;
                n_lane[l].sat   = w_in[l].sat;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[s]) begin
                r_lane[s] <= n_lane;
                r_side[s] <= w_side;
            end
        end
    end

    assign o_lane = r_lane[wsp_pkg::DIV_BITS - 1];
    assign o_side = r_side[wsp_pkg::DIV_BITS - 1];

endmodule

@@ hw/rtl/wsp_viewport.sv @@
module wsp_viewport (
    input  logic                  i_clk,
    input  logic [2:0]            i_en,
    input  logic [12:0]           i_width,
    input  logic [12:0]           i_height,
    input  wsp_pkg::t_div_lane    i_lane [3],
    input  wsp_pkg::t_div_side    i_side,
    output wsp_pkg::t_q16         o_screen_x,
    output wsp_pkg::t_q16         o_screen_y,
    output wsp_pkg::t_q16         o_depth,
    output logic                  o_visible
);

    wsp_pkg::t_q16      r_ndc [3];
    wsp_pkg::t_q16      n_ndc [3];
    logic               r_vis_a;
    logic               r_rej_a;
    logic signed [46:0] r_px;
    logic signed [46:0] r_py;
    wsp_pkg::t_q16      r_nz;
    logic               r_vis_b;
    logic               r_rej_b;
    wsp_pkg::t_q16      r_sx;
    wsp_pkg::t_q16      r_sy;
    wsp_pkg::t_q16      r_dz;
    logic               r_vis_c;
    logic               n_vis;
    logic signed [32:0] w_ax;
    logic signed [32:0] w_ay;
    logic signed [46:0] w_hx;
    logic signed [46:0] w_hy;

    always_comb begin
        logic [31:0] q;
        for (int l = 0; l < 3; l++) begin
            q = i_lane[l].quo;
            if (i_lane[l].neg) begin
                if (i_lane[l].sat || q > 32'h80000000) begin
                    n_ndc[l] = 32'sh80000000;
                end else begin
                    n_ndc[l] = $signed(~q + 32'd1);
                end
            end else begin
                if (i_lane[l].sat || q[31]) begin
                    n_ndc[l] = 32'sh7fffffff;
                end else begin
                    n_ndc[l] = $signed(q);
                end
            end
        end
        n_vis = n_ndc[0] >= wsp_pkg::Q_NEG_ONE && n_ndc[0] <= wsp_pkg::Q_ONE
             && n_ndc[1] >= wsp_pkg::Q_NEG_ONE && n_ndc[1] <= wsp_pkg::Q_ONE
             && n_ndc[2] >= 32'sd0 && n_ndc[2] <= wsp_pkg::Q_ONE;
    end

    assign w_ax = 33'(r_ndc[0]) + 33'(wsp_pkg::Q_ONE);
    assign w_ay = 33'(wsp_pkg::Q_ONE) - 33'(r_ndc[1]);
    assign w_hx = r_px >>> 1;
    assign w_hy = r_py >>> 1;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_ndc   <= n_ndc;
            r_vis_a <= n_vis;
            r_rej_a <= i_side.reject;
        end
        if (i_en[1]) begin
            r_px    <= w_ax * $signed({1'b0, i_width});
            r_py    <= w_ay * $signed({1'b0, i_height});
            r_nz    <= r_ndc[2];
            r_vis_b <= r_vis_a;
            r_rej_b <= r_rej_a;
        end
        if (i_en[2]) begin
            if (r_rej_b) begin
                r_sx    <= '0;
                r_sy    <= '0;
                r_dz    <= '0;
                r_vis_c <= 1'b0;
            end else begin
                r_sx    <= wsp_pkg::sat32($signed({{3{w_hx[46]}}, w_hx}));
                r_sy    <= wsp_pkg::sat32($signed({{3{w_hy[46]}}, w_hy}));
                r_dz    <= r_nz;
                r_vis_c <= r_vis_b;
            end
        end
    end

    assign o_screen_x = r_sx;
    assign o_screen_y = r_sy;
    assign o_depth    = r_dz;
    assign o_visible  = r_vis_c;

endmodule

@@ hw/rtl/world_to_screen_projection_unit.sv @@
// World to screen projection, signed Q16.16.
// Input channel (i_valid / o_stall): i_cmd selects a coefficient load or a
// point transform. A load writes i_coef_value into the matrix store at
// i_coef_index (0-15 view, 16-31 projection) and gives no result. A
// transform gives one result on the output channel (o_valid / i_stall):
// screen_x, screen_y, depth and visible.
// From the input transfer to the output, a point passes two stages per
// matrix product, one divider set-up stage, 32 stages of the bit-per-stage
// divider and three viewport stages. Throughput is one point per cycle
// while i_stall is low. A load waits while a point sits in the first two
// stages, so that points ahead of it still see the old projection matrix.
// Reset clears the matrix store and all stage valids and sets the viewport
// to 1920 x 1080; until matrices are loaded every point is rejected.
// A stalled result holds; stages behind it keep filling bubbles, and points
// at the input stall only once the pipeline is full.
// Viewport registers are written through i_cfg_we only while the block is
// idle; the user must keep to this, since the block has no check for it.
module world_to_screen_projection_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [12:0]          i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_cmd,
    input  logic [4:0]           i_coef_index,
    input  logic signed [31:0]   i_coef_value,
    input  logic signed [31:0]   i_world_x,
    input  logic signed [31:0]   i_world_y,
    input  logic signed [31:0]   i_world_z,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [31:0]   o_screen_x,
    output logic signed [31:0]   o_screen_y,
    output logic signed [31:0]   o_depth,
    output logic                 o_visible
);

    wsp_pkg::t_q16       r_mat [32];
    logic [12:0]         r_width;
    logic [12:0]         r_height;
    logic [40:1]         r_v;
    logic [40:1]         n_v;
    logic [41:1]         w_rdy;
    logic                w_acc_x;
    logic                w_acc_load;
    wsp_pkg::t_q16       w_world [4];
    wsp_pkg::t_q16       w_view [16];
    wsp_pkg::t_q16       w_proj [16];
    wsp_pkg::t_q16       w_eye [4];
    wsp_pkg::t_q16       w_clip [4];
    wsp_pkg::t_div_lane  r_lane [3];
    wsp_pkg::t_div_lane  n_lane [3];
    wsp_pkg::t_div_side  r_side;
    wsp_pkg::t_div_side  n_side;
    wsp_pkg::t_div_lane  w_dlane [3];
    wsp_pkg::t_div_side  w_dside;

    always_comb begin
        w_rdy[41] = !i_stall;
        for (int k = 40; k >= 1; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k + 1];
        end
    end

    assign o_stall    = (i_cmd == wsp_pkg::CMD_XFORM) ? !w_rdy[1] : (r_v[1] || r_v[2]);
    assign w_acc_x    = i_valid && !o_stall && i_cmd == wsp_pkg::CMD_XFORM;
    assign w_acc_load = i_valid && !o_stall && i_cmd == wsp_pkg::CMD_LOAD;
    assign n_v        = {r_v[39:1], w_acc_x};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
            for (int i = 0; i < 32; i++) begin
                r_mat[i] <= '0;
            end
            r_width  <= wsp_pkg::RESET_WIDTH;
            r_height <= wsp_pkg::RESET_HEIGHT;
        end else begin
            for (int k = 1; k <= 40; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= n_v[k];
                end
            end
            if (w_acc_load) begin
                r_mat[i_coef_index] <= i_coef_value;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    wsp_pkg::REG_SCREEN_WIDTH: begin
                        r_width <= i_cfg_data;
                    end
                    wsp_pkg::REG_SCREEN_HEIGHT: begin
                        r_height <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            w_view[i] = r_mat[i];
            w_proj[i] = r_mat[16 + i];
        end
    end

    assign w_world[0] = i_world_x;
    assign w_world[1] = i_world_y;
    assign w_world[2] = i_world_z;
    assign w_world[3] = wsp_pkg::Q_ONE;

    wsp_vec_mat u_view (
        .i_clk    (i_clk),
        .i_en_mul (w_rdy[1]),
        .i_en_sum (w_rdy[2]),
        .i_vec    (w_world),
        .i_mat    (w_view),
        .o_vec    (w_eye)
    );

    wsp_vec_mat u_proj (
        .i_clk    (i_clk),
        .i_en_mul (w_rdy[3]),
        .i_en_sum (w_rdy[4]),
        .i_vec    (w_eye),
        .i_mat    (w_proj),
        .o_vec    (w_clip)
    );

    always_comb begin
        logic [31:0] mag;
        n_side.cw     = w_clip[3][30:0];
        n_side.reject = w_clip[3] <= wsp_pkg::W_MIN;
        for (int l = 0; l < 3; l++) begin
            mag = w_clip[l][31] ? (~w_clip[l] + 32'd1) : w_clip[l];
            n_lane[l].neg   = w_clip[l][31];
            n_lane[l].sat   = {16'd0, mag} >= {1'b0, w_clip[3][30:0], 16'd0};
            n_lane[l].rem   = {15'd0, mag[31:16]};
            n_lane[l].dbits = {mag[15:0], 16'd0};
            n_lane[l].quo   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[5]) begin
            r_lane <= n_lane;
            r_side <= n_side;
        end
    end

    wsp_divider u_div (
        .i_clk  (i_clk),
        .i_en   (w_rdy[37:6]),
        .i_lane (r_lane),
        .i_side (r_side),
        .o_lane (w_dlane),
        .o_side (w_dside)
    );

    wsp_viewport u_vp (
        .i_clk      (i_clk),
        .i_en       (w_rdy[40:38]),
        .i_width    (r_width),
        .i_height   (r_height),
        .i_lane     (w_dlane),
        .i_side     (w_dside),
        .o_screen_x (o_screen_x),
        .o_screen_y (o_screen_y),
        .o_depth    (o_depth),
        .o_visible  (o_visible)
    );

    assign o_valid = r_v[40];

endmodule

@@ tb/wsp_result_checker.sv @@
`timescale 1ns / 100ps

module wsp_result_checker
    import wsp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [12:0] i_cfg_data,
    input  logic        i_valid,
    input  logic        i_stall_in,
    input  logic        i_cmd,
    input  logic [4:0]  i_coef_index,
    input  t_q16        i_coef_value,
    input  t_q16        i_world_x,
    input  t_q16        i_world_y,
    input  t_q16        i_world_z,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_q16        i_screen_x,
    input  t_q16        i_screen_y,
    input  t_q16        i_depth,
    input  logic        i_visible,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_points_seen,
    output int          o_visible_seen
);

    typedef struct {
        t_q16 sx;
        t_q16 sy;
        t_q16 depth;
        logic vis;
    } t_screen_pt;

    t_q16        coef_store [32];
    logic [12:0] view_w;
    logic [12:0] view_h;
    t_screen_pt  expected_pts [$];
    int          fails;
    int          points;
    int          vis_count;

    assign o_fail_count   = fails;
    assign o_pending      = expected_pts.size();
    assign o_points_seen  = points;
    assign o_visible_seen = vis_count;

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic t_screen_pt project(input t_q16 x, input t_q16 y, input t_q16 z);
        longint     world [4];
        longint     eye [4];
        longint     clip [4];
        longint     acc;
        longint     nx;
        longint     ny;
        longint     nz;
        t_screen_pt r;
        world[0] = x;
        world[1] = y;
        world[2] = z;
        world[3] = 65536;
        for (int c = 0; c < 4; c++) begin
            acc = 0;
            for (int k = 0; k < 4; k++) begin
                acc += (world[k] * longint'(coef_store[k * 4 + c])) >>> 16;
            end
            eye[c] = clamp32(acc);
        end
        for (int c = 0; c < 4; c++) begin
            acc = 0;
            for (int k = 0; k < 4; k++) begin
                acc += (eye[k] * longint'(coef_store[16 + k * 4 + c])) >>> 16;
            end
            clip[c] = clamp32(acc);
        end
        r.sx = '0;
        r.sy = '0;
        r.depth = '0;
        r.vis = 1'b0;
        if (clip[3] <= 6) return r;
        nx = clamp32((clip[0] * 65536) / clip[3]);
        ny = clamp32((clip[1] * 65536) / clip[3]);
        nz = clamp32((clip[2] * 65536) / clip[3]);
        r.sx = t_q16'(clamp32(((nx + 65536) * longint'(view_w)) >>> 1));
        r.sy = t_q16'(clamp32(((65536 - ny) * longint'(view_h)) >>> 1));
        r.depth = t_q16'(nz);
        r.vis = nx >= -65536 && nx <= 65536 && ny >= -65536 && ny <= 65536 &&
                nz >= 0 && nz <= 65536;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_screen_pt want;
        if (!i_rst_n) begin
            foreach (coef_store[k]) coef_store[k] = '0;
            view_w = RESET_WIDTH;
            view_h = RESET_HEIGHT;
            expected_pts.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_SCREEN_WIDTH) view_w = i_cfg_data;
                else view_h = i_cfg_data;
            end
            if (i_out_valid && !i_out_stall) begin
                points++;
                if (i_visible) vis_count++;
                if (expected_pts.size() == 0) begin
                    if (fails < 10) $display("unexpected result at %0t", $realtime);
                    fails++;
                end else begin
                    want = expected_pts.pop_front();
                    if (want.sx !== i_screen_x || want.sy !== i_screen_y ||
                        want.depth !== i_depth || want.vis !== i_visible) begin
                        if (fails < 10) begin
                            $display("mismatch at %0t: exp x=%0d y=%0d d=%0d v=%0b",
                                     $realtime, want.sx, want.sy, want.depth, want.vis);
                            $display("                 got x=%0d y=%0d d=%0d v=%0b",
                                     i_screen_x, i_screen_y, i_depth, i_visible);
                        end
                        fails++;
                    end
                end
            end
            if (i_valid && !i_stall_in) begin
                if (i_cmd == CMD_LOAD) coef_store[i_coef_index] = i_coef_value;
                else expected_pts.insert(expected_pts.size(),
                                         project(i_world_x, i_world_y, i_world_z));
            end
        end
    end

    initial begin
        fails = 0;
        points = 0;
        vis_count = 0;
    end

endmodule

@@ tb/tb_world_to_screen_projection_unit.sv @@
`timescale 1ns / 100ps

module tb_world_to_screen_projection_unit;
    import wsp_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = REG_SCREEN_WIDTH;
    logic [12:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_cmd = CMD_LOAD;
    logic [4:0]  i_coef_index = '0;
    t_q16        i_coef_value = '0;
    t_q16        i_world_x = '0;
    t_q16        i_world_y = '0;
    t_q16        i_world_z = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    t_q16        o_screen_x;
    t_q16        o_screen_y;
    t_q16        o_depth;
    logic        o_visible;

    int fail_count;
    int pending;
    int points_seen;
    int visible_seen;
    int stall_left;
    bit tx_gaps;
    bit rx_gaps;
    int items_sent;

    always #6 i_clk = ~i_clk;

    world_to_screen_projection_unit dut (.*);

    wsp_result_checker checker_i (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data, .i_valid,
        .i_stall_in(o_stall), .i_cmd, .i_coef_index, .i_coef_value,
        .i_world_x, .i_world_y, .i_world_z,
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_screen_x(o_screen_x), .i_screen_y(o_screen_y), .i_depth(o_depth),
        .i_visible(o_visible),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_points_seen(points_seen), .o_visible_seen(visible_seen)
    );

    always @(posedge i_clk) begin
        int d;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left <= 0;
        end else if (o_valid && !i_stall) begin
            d = rx_gaps ? $urandom_range(0, 19) : 0;
            i_stall <= d != 0;
            stall_left <= d > 0 ? d - 1 : 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    task automatic send(input logic cmd, input logic [4:0] idx, input t_q16 val,
                        input t_q16 x, input t_q16 y, input t_q16 z);
        int gap;
        gap = tx_gaps ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd <= cmd;
        i_coef_index <= idx;
        i_coef_value <= val;
        i_world_x <= x;
        i_world_y <= y;
        i_world_z <= z;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
    endtask

    task automatic load(input int idx, input t_q16 val);
        send(CMD_LOAD, idx[4:0], val, t_q16'($urandom), t_q16'($urandom), t_q16'($urandom));
    endtask

    task automatic point(input t_q16 x, input t_q16 y, input t_q16 z);
        send(CMD_XFORM, 5'($urandom), t_q16'($urandom), x, y, z);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (45) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [12:0] val);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // identity view with a translation row, perspective projection with cw = eye z
    task automatic load_camera(input t_q16 tx, input t_q16 ty, input t_q16 tz,
                               input t_q16 f, input t_q16 a, input t_q16 b);
        for (int k = 0; k < 32; k++) begin
            case (k)
                0, 5, 10, 15, 27: load(k, Q_ONE);
                12: load(k, tx);
                13: load(k, ty);
                14: load(k, tz);
                16, 21: load(k, f);
                26: load(k, a);
                30: load(k, b);
                default: load(k, '0);
            endcase
        end
    endtask

    function automatic t_q16 span(input int half);
        return t_q16'(int'($urandom_range(0, 2 * half)) - half);
    endfunction

    initial begin
        int zq;
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        items_sent = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty store: everything rejected
        point(Q_ONE, Q_ONE, 2 * Q_ONE);
        point(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        point(32'sh80000000, 32'sh80000000, 32'sh80000000);

        load_camera('0, '0, '0, Q_ONE, Q_ONE, Q_NEG_ONE);
        point('0, '0, 2 * Q_ONE);
        point(2 * Q_ONE, -2 * Q_ONE, 2 * Q_ONE);
        point(-2 * Q_ONE, 2 * Q_ONE, 2 * Q_ONE);
        point(Q_ONE, Q_ONE, Q_ONE);
        point('0, '0, 32'sd6);
        point('0, '0, 32'sd7);
        point(Q_ONE, -Q_ONE, 32'sd7);
        point('0, '0, -Q_ONE);
        point(32'sh7fffffff, 32'sh80000000, Q_ONE);
        point(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff);
        point(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000);

        write_reg(REG_SCREEN_WIDTH, 13'd8191);
        write_reg(REG_SCREEN_HEIGHT, 13'd1);
        point(Q_ONE / 2, -Q_ONE / 2, 2 * Q_ONE);
        point(32'sh7fffffff, 32'sh80000000, Q_ONE);
        write_reg(REG_SCREEN_WIDTH, 13'd0);
        write_reg(REG_SCREEN_HEIGHT, 13'd0);
        point(Q_ONE / 3, Q_ONE / 5, 3 * Q_ONE);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    write_reg(REG_SCREEN_WIDTH, 13'd1);
                    write_reg(REG_SCREEN_HEIGHT, 13'd8191);
                end
                1: begin
                    write_reg(REG_SCREEN_WIDTH, 13'($urandom_range(1, 8191)));
                    write_reg(REG_SCREEN_HEIGHT, 13'($urandom_range(1, 8191)));
                end
                2: begin
                    write_reg(REG_SCREEN_WIDTH, 13'd8191);
                    write_reg(REG_SCREEN_HEIGHT, 13'd8191);
                end
                default: begin
                    write_reg(REG_SCREEN_WIDTH, RESET_WIDTH);
                    write_reg(REG_SCREEN_HEIGHT, RESET_HEIGHT);
                end
            endcase
            tx_gaps = phase != 1;
            rx_gaps = phase != 1 && phase != 2;
            while (items_sent < 45 + 165 * (phase + 1)) begin
                if ($urandom_range(0, 39) == 0)
                    load_camera(span(5 * Q_ONE), span(5 * Q_ONE), span(5 * Q_ONE),
                                t_q16'(Q_ONE + $urandom_range(0, Q_ONE)),
                                t_q16'(Q_ONE + $urandom_range(0, 2000)),
                                t_q16'(-$urandom_range(Q_ONE / 2, 2 * Q_ONE)));
                case ($urandom_range(0, 19))
                    0: load($urandom_range(0, 31), t_q16'($urandom));
                    1, 2: point(t_q16'($urandom), t_q16'($urandom), t_q16'($urandom));
                    default: begin
                        zq = $urandom_range(0, 60 * Q_ONE);
                        point(span(zq + Q_ONE), span(zq + Q_ONE),
                              t_q16'(zq - $urandom_range(0, 8 * Q_ONE)));
                    end
                endcase
            end
        end

        drain();
        $display("covered %0d points (%0d visible) over loads, rejections and viewport extremes",
                 points_seen, visible_seen);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule
